[rtl/core/cpcs_pkg.sv]
package cpcs_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned OpW       = 6;
  localparam int unsigned GprCount  = 32;
  localparam int unsigned GprIdxW   = $clog2(GprCount);
  localparam int unsigned RangeCnt  = 3;
  localparam int unsigned CfgIdxW   = 3;

  // primary opcodes of interest
  localparam logic [OpW-1:0] OP_ADDI  = 6'd14;
  localparam logic [OpW-1:0] OP_ADDIS = 6'd15;
  localparam logic [OpW-1:0] OP_BC    = 6'd16;
  localparam logic [OpW-1:0] OP_B     = 6'd18;
  localparam logic [OpW-1:0] OP_XL    = 6'd19;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEXT0_BASE = 3'd0,
    CFG_TEXT0_SIZE = 3'd1,
    CFG_TEXT1_BASE = 3'd2,
    CFG_TEXT1_SIZE = 3'd3,
    CFG_TEXT2_BASE = 3'd4,
    CFG_TEXT2_SIZE = 3'd5
  } cfg_idx_e;

  // table update, applied when a word leaves the lookup stage
  typedef struct packed {
    logic               en;
    logic               clr_all;
    logic               set_en;
    logic               clr_en;
    logic [GprIdxW-1:0] rd;
    logic [HalfW-1:0]   half;
  } tbl_upd_t;

  // table read, issued when a word is accepted
  typedef struct packed {
    logic               en;
    logic [GprIdxW-1:0] addr;
  } tbl_rd_t;

endpackage

[rtl/core/cpcs_table.sv]
module cpcs_table
  import cpcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_rd_t          rd_i,
  input  tbl_upd_t         upd_i,
  output logic [HalfW-1:0] half_o
);

  logic [HalfW-1:0]    mem_q [GprCount];
  logic [GprCount-1:0] valid_q, valid_d;
  logic [HalfW-1:0]    rdata_q;
  logic [GprIdxW-1:0]  raddr_q;
  logic                fwd_q;
  logic [HalfW-1:0]    fwd_data_q;
  logic                wr_en;

  assign wr_en = upd_i.en && upd_i.set_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[upd_i.rd] <= upd_i.half;
    end
    if (rd_i.en) begin
      rdata_q    <= mem_q[rd_i.addr];
      fwd_data_q <= upd_i.half;
    end
  end

  // same-edge write bypasses the old read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raddr_q <= '0;
      fwd_q   <= 1'b0;
    end else if (rd_i.en) begin
      raddr_q <= rd_i.addr;
      fwd_q   <= wr_en && (upd_i.rd == rd_i.addr);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (upd_i.en) begin
      if (upd_i.clr_all) valid_d = '0;
      if (upd_i.set_en) valid_d[upd_i.rd] = 1'b1;
      if (upd_i.clr_en) valid_d[upd_i.rd] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign half_o = valid_q[raddr_q] ? (fwd_q ? fwd_data_q : rdata_q) : '0;

endmodule

[rtl/core/cpcs_range.sv]
module cpcs_range
  import cpcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_wdata_i,
  input  logic [WordW-1:0]   addr_i,
  output logic               hit_o
);

  logic [WordW-1:0] base_q [RangeCnt];
  logic [WordW-1:0] size_q [RangeCnt];
  logic [RangeCnt-1:0] in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RangeCnt; k++) begin
        base_q[k] <= '0;
        size_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TEXT0_BASE: base_q[0] <= cfg_wdata_i;
        CFG_TEXT0_SIZE: size_q[0] <= cfg_wdata_i;
        CFG_TEXT1_BASE: base_q[1] <= cfg_wdata_i;
        CFG_TEXT1_SIZE: size_q[1] <= cfg_wdata_i;
        CFG_TEXT2_BASE: base_q[2] <= cfg_wdata_i;
        CFG_TEXT2_SIZE: size_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // offset from base, mod 2^32, below size; wraps past top of space
  always_comb begin
    for (int k = 0; k < RangeCnt; k++) begin
      in_range[k] = (addr_i - base_q[k]) < size_q[k];
    end
  end

  assign hit_o = (addr_i[1:0] == 2'b00) && (|in_range);

endmodule

[rtl/core/code_pointer_candidate_scanner.sv]
// Code pointer candidate scanner.
// Input channel: one section word per handshake (word_i, in_code_section_i,
// section_first_i) under in_valid_i / in_stall_o. Output channel: one
// candidate word (candidate_address_o, found_in_data_o) under out_valid_o /
// out_stall_i. Words that yield no candidate produce nothing on the output.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0..5 = text0_base, text0_size, text1_base, text1_size, text2_base,
// text2_size); indexes 6 and 7 are ignored. Write only while idle.
// Pipeline: accept (table read issued) -> lookup/decode (table update)
// -> range check -> output register. out_valid_o rises once its word has
// passed the lookup and range stages into the output register.
// Throughput is one word per cycle while the output is not stalled, set
// by the read-modify-write of the 32-entry pending-half memory; a write
// that lands on the edge of the next read is bypassed.
// Reset: all range registers zero (no code ranges), pending table empty
// (valid bits cleared at once, no sweep), pipeline empty.
// Stall: a stalled output holds its word; the range stage and then the
// lookup stage back up, and in_stall_o rises only when all are full.
module code_pointer_candidate_scanner
  import cpcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [WordW-1:0]   word_i,
  input  logic               in_code_section_i,
  input  logic               section_first_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WordW-1:0]   candidate_address_o,
  output logic               found_in_data_o
);

  logic             accept;
  // lookup stage
  logic             s1_valid_q, s1_valid_d;
  logic [WordW-1:0] s1_word_q;
  logic             s1_code_q, s1_first_q;
  // range stage
  logic             s2_valid_q, s2_valid_d;
  logic [WordW-1:0] s2_addr_q;
  logic             s2_data_q;
  // output register
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_addr_q;
  logic             out_data_q;

  logic               s1_adv, s2_adv, s2_free, out_free, hit;
  logic [OpW-1:0]     op;
  logic [GprIdxW-1:0] rd, ra;
  logic [HalfW-1:0]   imm, lk_half, hi;
  logic               is_addis, is_addi, is_branch;
  logic               cand_en;
  logic [WordW-1:0]   target, cand_addr;
  tbl_rd_t            tbl_rd;
  tbl_upd_t           tbl_upd;

  assign accept = in_valid_i && !in_stall_o;

  // decode of the word in the lookup stage
  assign op  = s1_word_q[31:26];
  assign rd  = s1_word_q[25:21];
  assign ra  = s1_word_q[20:16];
  assign imm = s1_word_q[15:0];

  assign is_addis  = (op == OP_ADDIS) && (ra == '0);
  assign is_addi   = (op == OP_ADDI);
  assign is_branch = (op == OP_B) || (op == OP_XL) || (op == OP_BC);

  // section start empties the table before this word looks at it
  assign hi     = s1_first_q ? '0 : lk_half;
  assign target = {hi, {HalfW{1'b0}}} + {{HalfW{imm[HalfW-1]}}, imm};

  assign cand_en   = s1_code_q ? (is_addi && (hi != '0)) : 1'b1;
  assign cand_addr = s1_code_q ? target : s1_word_q;

  // handshake chain, output side first
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_adv     = s2_valid_q && (!hit || out_free);
  assign s2_free    = !s2_valid_q || s2_adv;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s1_adv;

  // ADDI reads rA here, then its rD is dropped
  assign tbl_rd.en   = accept;
  assign tbl_rd.addr = word_i[20:16];

  always_comb begin
    tbl_upd.en      = s1_adv;
    tbl_upd.clr_all = s1_first_q || (s1_code_q && is_branch);
    tbl_upd.set_en  = s1_code_q && is_addis;
    tbl_upd.clr_en  = s1_code_q && !is_addis && !is_branch;
    tbl_upd.rd      = rd;
    tbl_upd.half    = imm;
  end

  cpcs_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (tbl_rd),
    .upd_i  (tbl_upd),
    .half_o (lk_half)
  );

  cpcs_range u_range (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .addr_i      (s2_addr_q),
    .hit_o       (hit)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;

    s2_valid_d = s2_valid_q;
    if (s1_adv && cand_en) s2_valid_d = 1'b1;
    else if (s2_adv) s2_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (s2_adv && hit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q  <= word_i;
      s1_code_q  <= in_code_section_i;
      s1_first_q <= section_first_i;
    end
    if (s1_adv && cand_en) begin
      s2_addr_q <= cand_addr;
      s2_data_q <= !s1_code_q;
    end
    if (s2_adv && hit) begin
      out_addr_q <= s2_addr_q;
      out_data_q <= s2_data_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign candidate_address_o = out_addr_q;
  assign found_in_data_o     = out_data_q;

endmodule

[rtl/core/cpcs_checker.sv]
module cpcs_checker
  import cpcs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_i,
  input logic             out_valid_i,
  input logic             out_stall_i,
  input logic [WordW-1:0] candidate_address_i
);

  // a held word stays on the port
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(candidate_address_i))
    else $error("output word dropped or changed while stalled");

  // candidates are always word aligned
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> candidate_address_i[1:0] == 2'b00)
    else $error("unaligned candidate");

  // input backs up only behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled with free output");

  // output cannot be valid in the first cycle out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind code_pointer_candidate_scanner cpcs_checker u_cpcs_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_stall_i          (in_stall_o),
  .out_valid_i         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .candidate_address_i (candidate_address_o)
);
